[design/b32d_pkg.sv]
// b32d_pkg: shared types and constants of the base32 string decoder.
// No dependencies; used by every module in design/.

package b32d_pkg;

    // Longest string length honored; longer lengths saturate to it
    localparam int MAX_CHARS = 4096;

    // Default depth of the queue between the front and back ends
    localparam int QUEUE_DEPTH = 4;

    // Character classes of the base32 alphabet
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_2 = 8'h32;
    localparam logic [7:0] CH_DIGIT_7 = 8'h37;
    // '2' maps to digit 26, so subtract '2' - 26
    localparam logic [7:0] DIGIT_BIAS = 8'h18;

    localparam int BITS_PER_DIGIT = 5;
    localparam int BITS_PER_BYTE  = 8;

    // Classified character, as queued between front and back end
    typedef struct packed {
        logic [4:0]  digit;
        logic        digit_ok;
        logic        first;
        logic [11:0] limit;
        logic        last;
    } ent_t;

    // One result beat
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        end_of_string;
        logic [11:0] decoded_length;
        logic [11:0] pad_zero_count;
    } res_t;

endpackage

[design/b32d_front.sv]
// b32d_front: classifies one input character into a base32 digit and
// turns the string length into the byte limit. Depends on b32d_pkg.

module b32d_front
(
    input  logic [7:0]     symbol,
    input  logic           first_symbol,
    input  logic [11:0]    string_length,
    input  logic           last_symbol,
    output b32d_pkg::ent_t ent
);

    logic [7:0]  digit_wide;
    logic        digit_ok;
    logic [11:0] len_sat;
    logic [14:0] len_x5;

    // Alphabet lookup: A-Z / a-z -> 0..25, 2-7 -> 26..31, rest skipped
    always_comb
    begin
        digit_ok   = 1'b1;
        digit_wide = 8'h00;
        case (symbol) inside
            [b32d_pkg::CH_UPPER_A:b32d_pkg::CH_UPPER_Z]:
                digit_wide = symbol - b32d_pkg::CH_UPPER_A;
            [b32d_pkg::CH_LOWER_A:b32d_pkg::CH_LOWER_Z]:
                digit_wide = symbol - b32d_pkg::CH_LOWER_A;
            [b32d_pkg::CH_DIGIT_2:b32d_pkg::CH_DIGIT_7]:
                digit_wide = symbol - b32d_pkg::DIGIT_BIAS;
            default:
                digit_ok = 1'b0;
        endcase
    end

    // Byte limit = floor(len * 5 / 8), length saturated first
    assign len_sat = ({20'd0, string_length} > 32'(b32d_pkg::MAX_CHARS))
                     ? 12'(b32d_pkg::MAX_CHARS) : string_length;
    assign len_x5  = {1'b0, len_sat, 2'b00} + {3'b000, len_sat};

    assign ent.digit    = digit_wide[4:0];
    assign ent.digit_ok = digit_ok;
    assign ent.first    = first_symbol;
    assign ent.limit    = len_x5[14:3];
    assign ent.last     = last_symbol;

endmodule

[design/b32d_queue.sv]
// b32d_queue: small FIFO of classified characters between the front and
// back ends. Depends on b32d_pkg for the entry type.

module b32d_queue
#(
    parameter int DEPTH = b32d_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b32d_pkg::ent_t push_ent,
    output logic           full,
    input  logic           pop,
    output b32d_pkg::ent_t head,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b32d_pkg::ent_t    store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

[design/b32d_back.sv]
// b32d_back: packs digits into bytes, applies the byte limit, flushes on
// the last character and drives the result register. Depends on b32d_pkg.

module b32d_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  b32d_pkg::ent_t   head,
    input  logic             not_empty,
    output logic             pop,
    output b32d_pkg::res_t   res,
    output logic             res_valid,
    input  logic             res_ready
);

    // Packing state
    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  bitpos_reg, bitpos_next;
    logic [11:0] emitted_reg, emitted_next;
    logic [11:0] limit_reg, limit_next;
    logic        reached_reg, reached_next;

    // Output register and the held second result of a step
    b32d_pkg::res_t out_reg, pend_reg;
    logic           out_valid_reg, pend_valid_reg;

    // Intermediate values of one step
    logic [7:0]  p0;
    logic [2:0]  b0;
    logic [11:0] e0, l0, e1;
    logic        r0, r1;
    logic [7:0]  p1;
    logic [2:0]  b1;
    logic [3:0]  np;
    logic [12:0] shifted;
    logic        byte_emit, flush_emit;
    logic [7:0]  done_byte;
    logic [11:0] pad;
    b32d_pkg::res_t res_a, res_b, end_fields;
    logic        have_a, have_b;
    logic        can_take;

    assign can_take = !out_valid_reg || res_ready;
    assign pop      = can_take && !pend_valid_reg && not_empty;

    // One character step: first-load, digit pack, flush, end report, result ordering
    always_comb
    begin
        // start of string loads the limit
        p0 = head.first ? 8'h00  : partial_reg;
        b0 = head.first ? 3'd0   : bitpos_reg;
        e0 = head.first ? 12'd0  : emitted_reg;
        l0 = head.first ? head.limit : limit_reg;
        r0 = head.first ? (head.limit == 12'd0) : reached_reg;

        // digit placement
        np        = {1'b0, b0} + 4'(b32d_pkg::BITS_PER_DIGIT);
        shifted   = {head.digit, 8'h00} >> np[2:0];
        byte_emit = head.digit_ok && !r0 && (e0 < l0) && np[3];
        p1        = p0;
        b1        = b0;
        e1        = e0;
        r1        = r0;
        done_byte = p0 | {3'b000, shifted[12:8]};
        if (head.digit_ok && !r0 && (e0 < l0))
        begin
            b1 = np[2:0];
            if (np[3])
            begin
                p1 = shifted[7:0];
                e1 = e0 + 12'd1;
                r1 = r0 || (e1 >= l0);
            end
            else
            begin
                p1 = p0 | shifted[7:0];
            end
        end

        // flush of a pending partial byte
        flush_emit   = head.last && !r1 && (b1 != 3'd0) && (e1 < l0);
        partial_next = p1;
        bitpos_next  = b1;
        emitted_next = e1;
        reached_next = r1;
        limit_next   = l0;
        if (flush_emit)
        begin
            emitted_next = e1 + 12'd1;
            reached_next = r1 || (emitted_next >= l0);
        end
        if (head.last)
        begin
            partial_next = 8'h00;
            bitpos_next  = 3'd0;
        end

        // end-of-string report
        pad = (l0 >= emitted_next) ? (l0 - emitted_next) : 12'd0;
        end_fields                = '0;
        end_fields.end_of_string  = 1'b1;
        end_fields.decoded_length = l0;
        end_fields.pad_zero_count = pad;

        // result ordering: completed byte, then flushed byte, end on last
        res_a  = '0;
        res_b  = '0;
        have_a = 1'b0;
        have_b = 1'b0;
        if (byte_emit && flush_emit)
        begin
            have_a           = 1'b1;
            res_a.data_byte  = done_byte;
            res_a.byte_valid = 1'b1;
            have_b           = 1'b1;
            res_b            = end_fields;
            res_b.data_byte  = p1;
            res_b.byte_valid = 1'b1;
        end
        else if (byte_emit)
        begin
            have_a           = 1'b1;
            res_a            = head.last ? end_fields : '0;
            res_a.data_byte  = done_byte;
            res_a.byte_valid = 1'b1;
        end
        else if (flush_emit)
        begin
            have_a           = 1'b1;
            res_a            = end_fields;
            res_a.data_byte  = p1;
            res_a.byte_valid = 1'b1;
        end
        else if (head.last)
        begin
            have_a = 1'b1;
            res_a  = end_fields;
        end
    end

    // Packing state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 8'h00;
            bitpos_reg  <= 3'd0;
            emitted_reg <= 12'd0;
            limit_reg   <= 12'd0;
            reached_reg <= 1'b0;
        end
        else if (pop)
        begin
            partial_reg <= partial_next;
            bitpos_reg  <= bitpos_next;
            emitted_reg <= emitted_next;
            limit_reg   <= limit_next;
            reached_reg <= reached_next;
        end
    end

    // Output and pending valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (not_empty)
            begin
                out_valid_reg  <= have_a;
                pend_valid_reg <= have_b;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output and pending payload
    always_ff @(posedge clk)
    begin
        if (can_take)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
            else if (not_empty)
            begin
                out_reg  <= res_a;
                pend_reg <= res_b;
            end
        end
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

endmodule

[design/base32_string_decoder.sv]
// base32_string_decoder: top level of the streaming base32 text decoder.
// Depends on b32d_pkg, b32d_front, b32d_queue and b32d_back.

// Takes one character beat per clock while the queue has room and returns
// decoded bytes on the result channel. A character beat is accepted whenever
// the classified character queue (QUEUE_DEPTH entries) has room, so input
// flow does not wait on a stalled result side until the queue fills. The
// back end takes one queued character per cycle unless the result side
// stalls; a character that both completes a byte and flushes the partial
// byte on the last symbol yields two result beats and holds the back end
// until the second beat has moved into the result register. The first
// result of a character passes through the queue storage and then the
// result register. Non-alphabet characters produce no beat, except that
// the last character of a string always produces at least one beat
// carrying end_of_string, decoded_length and pad_zero_count.

module base32_string_decoder
#(
    parameter int QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sym_valid,
    output logic        sym_ready,
    input  logic [7:0]  symbol,
    input  logic        first_symbol,
    input  logic [11:0] string_length,
    input  logic        last_symbol,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [7:0]  data_byte,
    output logic        byte_valid,
    output logic        end_of_string,
    output logic [11:0] decoded_length,
    output logic [11:0] pad_zero_count
);

    b32d_pkg::ent_t front_ent;
    b32d_pkg::ent_t head;
    b32d_pkg::res_t res;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    logic           q_push;

    assign sym_ready = !q_full;
    assign q_push    = sym_valid && !q_full;

    b32d_front u_front
    (
        .symbol        (symbol),
        .first_symbol  (first_symbol),
        .string_length (string_length),
        .last_symbol   (last_symbol),
        .ent           (front_ent)
    );

    b32d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ent  (front_ent),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head),
        .not_empty (q_not_empty)
    );

    b32d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    assign data_byte      = res.data_byte;
    assign byte_valid     = res.byte_valid;
    assign end_of_string  = res.end_of_string;
    assign decoded_length = res.decoded_length;
    assign pad_zero_count = res.pad_zero_count;

endmodule

[sim/b32d_checker.sv]
// b32d_checker: watches the character and result channels of the base32 decoder,
// predicts every result beat and compares it against what the block returns.
// Depends on b32d_pkg for the result layout and the alphabet constants.
`timescale 1ns / 1ps

module b32d_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sym_valid,
    input  logic        sym_ready,
    input  logic [7:0]  symbol,
    input  logic        first_symbol,
    input  logic [11:0] string_length,
    input  logic        last_symbol,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_string,
    input  logic [11:0] decoded_length,
    input  logic [11:0] pad_zero_count,
    output int          fail_count,
    output int          pending_results
);

    // Predicted decoder state
    logic [7:0]  pack_reg;
    int          pack_bits;
    logic [11:0] byte_count;
    logic [11:0] byte_cap;
    logic        cap_hit;

    // Result beats still owed by the block, oldest first
    b32d_pkg::res_t decoded_q[$];
    int             report_count;

    // {is_digit, digit} for one raw character
    function automatic logic [5:0] char_to_digit(input logic [7:0] ch);
        logic [5:0] code;
        code = 6'd0;
        if (ch >= b32d_pkg::CH_UPPER_A && ch <= b32d_pkg::CH_UPPER_Z)
            code = {1'b1, 5'(ch - b32d_pkg::CH_UPPER_A)};
        else if (ch >= b32d_pkg::CH_LOWER_A && ch <= b32d_pkg::CH_LOWER_Z)
            code = {1'b1, 5'(ch - b32d_pkg::CH_LOWER_A)};
        else if (ch >= b32d_pkg::CH_DIGIT_2 && ch <= b32d_pkg::CH_DIGIT_7)
            code = {1'b1, 5'(ch - b32d_pkg::DIGIT_BIAS)};
        return code;
    endfunction

    // Queue one decoded byte and bump the emitted count
    task automatic push_byte(input logic [7:0] b);
        b32d_pkg::res_t beat;
        beat = '0;
        beat.data_byte = b;
        beat.byte_valid = 1'b1;
        decoded_q.push_back(beat);
        byte_count = byte_count + 12'd1;
        if (byte_count >= byte_cap)
            cap_hit = 1'b1;
    endtask

    // Work out the result beats caused by one accepted character beat
    task automatic decode_symbol(input logic [7:0] ch, input logic first,
                                 input logic [11:0] len, input logic last);
        logic [5:0]     code;
        logic [7:0]     digit8;
        logic [7:0]     full;
        int             total;
        int             spill;
        int             beats;
        int             chars;
        b32d_pkg::res_t tail;
        beats = 0;
        if (first)
        begin
            chars = (int'(len) > b32d_pkg::MAX_CHARS) ? b32d_pkg::MAX_CHARS : int'(len);
            pack_reg = 8'd0;
            pack_bits = 0;
            byte_count = 12'd0;
            byte_cap = 12'((chars * b32d_pkg::BITS_PER_DIGIT) / b32d_pkg::BITS_PER_BYTE);
            cap_hit = (byte_cap == 12'd0);
        end

        // Pack the digit MSB first, emit a byte when eight bits are in
        code = char_to_digit(ch);
        digit8 = {3'b000, code[4:0]};
        if (code[5] && !cap_hit && byte_count < byte_cap)
        begin
            total = pack_bits + b32d_pkg::BITS_PER_DIGIT;
            if (total < b32d_pkg::BITS_PER_BYTE)
            begin
                pack_reg = pack_reg | 8'(digit8 << (b32d_pkg::BITS_PER_BYTE - total));
                pack_bits = total;
            end
            else
            begin
                spill = total - b32d_pkg::BITS_PER_BYTE;
                full = pack_reg | (digit8 >> spill);
                pack_reg = 8'(digit8 << (b32d_pkg::BITS_PER_BYTE - spill));
                pack_bits = spill;
                push_byte(full);
                beats++;
            end
        end

        // End of string: flush, then tag the last beat (or a new bare one) with the summary
        if (last)
        begin
            if (!cap_hit && pack_bits != 0 && byte_count < byte_cap)
            begin
                push_byte(pack_reg);
                beats++;
            end
            pack_reg = 8'd0;
            pack_bits = 0;
            if (beats == 0)
            begin
                tail = '0;
            end
            else
            begin
                tail = decoded_q.pop_back();
            end
            tail.end_of_string = 1'b1;
            tail.decoded_length = byte_cap;
            tail.pad_zero_count = (byte_cap >= byte_count) ? (byte_cap - byte_count) : 12'd0;
            decoded_q.push_back(tail);
        end
    endtask

    // Compare one returned beat with the oldest expectation
    task automatic check_beat();
        b32d_pkg::res_t want;
        b32d_pkg::res_t got;
        got.data_byte = data_byte;
        got.byte_valid = byte_valid;
        got.end_of_string = end_of_string;
        got.decoded_length = decoded_length;
        got.pad_zero_count = pad_zero_count;
        if (decoded_q.size() == 0)
        begin
            fail_count++;
            if (report_count < 10)
            begin
                report_count++;
                $display("[%0t] unexpected result beat: byte=%02h v=%0b end=%0b len=%0d pad=%0d",
                         $time, got.data_byte, got.byte_valid, got.end_of_string,
                         got.decoded_length, got.pad_zero_count);
            end
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
                got.end_of_string !== want.end_of_string ||
                got.decoded_length !== want.decoded_length ||
                got.pad_zero_count !== want.pad_zero_count)
            begin
                fail_count++;
                if (report_count < 10)
                begin
                    report_count++;
                    $display("[%0t] result mismatch: exp byte=%02h v=%0b end=%0b len=%0d pad=%0d",
                             $time, want.data_byte, want.byte_valid, want.end_of_string,
                             want.decoded_length, want.pad_zero_count);
                    $display("[%0t]                  got byte=%02h v=%0b end=%0b len=%0d pad=%0d",
                             $time, got.data_byte, got.byte_valid, got.end_of_string,
                             got.decoded_length, got.pad_zero_count);
                end
            end
        end
    endtask

    // Channel monitor: character beats first, then result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_reg = 8'd0;
            pack_bits = 0;
            byte_count = 12'd0;
            byte_cap = 12'd0;
            cap_hit = 1'b0;
            decoded_q.delete();
            fail_count = 0;
            report_count = 0;
            pending_results <= 0;
        end
        else
        begin
            if (sym_valid && sym_ready)
                decode_symbol(symbol, first_symbol, string_length, last_symbol);
            if (res_valid && res_ready)
                check_beat();
            pending_results <= decoded_q.size();
        end
    end

endmodule

[sim/tb_top.sv]
// tb_top: stimulus, clock, reset and verdict for the base32 string decoder.
// Depends on b32d_pkg, base32_string_decoder and b32d_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 950;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sym_valid = 1'b0;
    logic        sym_ready;
    logic [7:0]  symbol = 8'd0;
    logic        first_symbol = 1'b0;
    logic [11:0] string_length = 12'd0;
    logic        last_symbol = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_string;
    logic [11:0] decoded_length;
    logic [11:0] pad_zero_count;

    int fail_count;
    int pending_results;
    int send_idle_pct = 14;
    int recv_stall_pct = 64;
    int idle_cycles = 0;

    base32_string_decoder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sym_valid      (sym_valid),
        .sym_ready      (sym_ready),
        .symbol         (symbol),
        .first_symbol   (first_symbol),
        .string_length  (string_length),
        .last_symbol    (last_symbol),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_string  (end_of_string),
        .decoded_length (decoded_length),
        .pad_zero_count (pad_zero_count)
    );

    b32d_checker u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .sym_valid       (sym_valid),
        .sym_ready       (sym_ready),
        .symbol          (symbol),
        .first_symbol    (first_symbol),
        .string_length   (string_length),
        .last_symbol     (last_symbol),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .data_byte       (data_byte),
        .byte_valid      (byte_valid),
        .end_of_string   (end_of_string),
        .decoded_length  (decoded_length),
        .pad_zero_count  (pad_zero_count),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Result side back-pressure
    always @(posedge clk)
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sym_valid && sym_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Mostly alphabet characters in random case, some arbitrary bytes
    function automatic logic [7:0] pick_char(input int junk_pct);
        int d;
        if ($urandom_range(0, 99) < junk_pct)
            return 8'($urandom_range(0, 255));
        d = $urandom_range(0, 31);
        if (d >= 26)
            return b32d_pkg::CH_DIGIT_2 + 8'(d - 26);
        if ($urandom_range(0, 1) == 1)
            return b32d_pkg::CH_UPPER_A + 8'(d);
        return b32d_pkg::CH_LOWER_A + 8'(d);
    endfunction

    // Present one character beat and hold it until accepted
    task automatic send_beat(input logic [7:0] ch, input logic first,
                             input logic [11:0] len, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sym_valid <= 1'b0;
            @(posedge clk);
        end
        sym_valid <= 1'b1;
        symbol <= ch;
        first_symbol <= first;
        string_length <= len;
        last_symbol <= last;
        @(posedge clk);
        while (!sym_ready)
            @(posedge clk);
    endtask

    // Fixed text as one string; length rides only on the first beat
    task automatic send_text(input string s, input logic [11:0] len);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], i == 0, (i == 0) ? len : 12'($urandom_range(0, 4095)),
                      i == s.len() - 1);
    endtask

    // Random string of n characters
    task automatic send_string(input int n, input logic [11:0] len, input bit terminate,
                               input int junk_pct);
        for (int i = 0; i < n; i++)
            send_beat(pick_char(junk_pct), i == 0,
                      (i == 0) ? len : 12'($urandom_range(0, 4095)),
                      terminate && (i == n - 1));
    endtask

    // Hold the character side off until every expected beat is back
    task automatic drain_results();
        sym_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int n;
        int random_items;
        int phase;
        random_items = 0;
        phase = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no string opened yet, end reports zero length
        send_beat("A", 1'b0, 12'd0, 1'b1);
        // Full block with a pad character
        send_text("MZXW6YQ=", 12'd8);
        // Lower case and digits; last character completes a byte and flushes one
        send_text("mf2G", 12'd8);
        // First and last together: zero limit, then a one-byte limit with flush
        send_beat("7", 1'b1, 12'd1, 1'b1);
        send_beat("z", 1'b1, 12'd2, 1'b1);
        // Limit reached mid-string: later characters ignored, no flush
        send_beat("a", 1'b1, 12'd2, 1'b0);
        send_beat("b", 1'b0, 12'd0, 1'b0);
        send_beat(8'hFF, 1'b0, 12'hFFF, 1'b0);
        send_beat(8'h00, 1'b0, 12'd0, 1'b1);
        // Longest length, alphabet boundary neighbors skipped
        send_text("`@8[1{7", 12'hFFF);
        drain_results();

        // Random strings across three flow-control phases
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase == 0 && random_items >= RANDOM_ITEMS / 3)
            begin
                drain_results();
                send_idle_pct <= 64;
                recv_stall_pct <= 14;
                phase = 1;
            end
            if (phase == 1 && random_items >= (2 * RANDOM_ITEMS) / 3)
            begin
                drain_results();
                send_idle_pct <= 0;
                recv_stall_pct <= 0;
                phase = 2;
            end

            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // well-formed string, length matches, an occasional long one
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 160)
                                                 : $urandom_range(1, 24);
                send_string(n, 12'(n), 1'b1, 15);
                random_items += n;
            end
            else if (kind < 82)
            begin
                // length field unrelated to the character count
                n = $urandom_range(1, 16);
                send_string(n, 12'($urandom_range(0, 4095)), 1'b1, 20);
                random_items += n;
            end
            else if (kind < 90)
            begin
                // string cut off before its last character
                n = $urandom_range(1, 12);
                send_string(n, 12'(n + $urandom_range(0, 8)), 1'b0, 20);
                random_items += n;
            end
            else
            begin
                // stray beats outside any string
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_beat(pick_char(40), 1'b0, 12'($urandom_range(0, 4095)),
                              $urandom_range(0, 99) < 30);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
design/b32d_pkg.sv
design/b32d_front.sv
design/b32d_queue.sv
design/b32d_back.sv
design/base32_string_decoder.sv
sim/b32d_checker.sv
sim/tb_top.sv
